// ===== rtl/one_wire_bus_master_core_assert.svh =====
// assertion macros used by the checker file
`ifndef ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one-wire master check failed");

// next-cycle implication, checked while out of reset
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one-wire master check failed");

`endif

// ===== rtl/owm_pkg.sv =====
`default_nettype none

package owm_pkg;

    localparam int TIME_W        = 10;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int CFG_IDX_W     = 3;

    localparam logic [TIME_W-1:0] RESET_LOW_TIME_RST        = 10'd500;
    localparam logic [TIME_W-1:0] PRESENCE_SAMPLE_DELAY_RST = 10'd125;
    localparam logic [TIME_W-1:0] SLOT_TIME_RST             = 10'd90;
    localparam logic [TIME_W-1:0] SLOT_LOW_TIME_RST         = 10'd5;
    localparam logic [TIME_W-1:0] READ_SAMPLE_DELAY_RST     = 10'd15;

    // command codes carried by the mode field
    localparam logic [1:0] MODE_RESET  = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // timing register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW_TIME        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SAMPLE_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TIME             = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW_TIME         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE_DELAY     = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_sample_delay;
        logic [TIME_W-1:0] slot_time;
        logic [TIME_W-1:0] slot_low_time;
        logic [TIME_W-1:0] read_sample_delay;
    } cfg_t;

    typedef struct packed {
        logic                     drive_low;
        logic                     busy_res;
        logic                     done_res;
        logic                     presence;
        logic [BITS_PER_BYTE-1:0] read_byte;
    } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/owm_cfg.sv =====
`default_nettype none

module owm_cfg (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           wr_en,
    input  wire [owm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire [owm_pkg::TIME_W-1:0]     wr_data,
    output owm_pkg::cfg_t                 cfg
);

    localparam logic [owm_pkg::CFG_IDX_W-1:0] IDX_RESET_LOW  = owm_pkg::REG_RESET_LOW_TIME;
    localparam logic [owm_pkg::CFG_IDX_W-1:0] IDX_PRES_DELAY =
        owm_pkg::REG_PRESENCE_SAMPLE_DELAY;
    localparam logic [owm_pkg::CFG_IDX_W-1:0] IDX_SLOT_TIME  = owm_pkg::REG_SLOT_TIME;
    localparam logic [owm_pkg::CFG_IDX_W-1:0] IDX_SLOT_LOW   = owm_pkg::REG_SLOT_LOW_TIME;
    localparam logic [owm_pkg::CFG_IDX_W-1:0] IDX_READ_DELAY = owm_pkg::REG_READ_SAMPLE_DELAY;

    owm_pkg::cfg_t cfg_reg;
    owm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                IDX_RESET_LOW:  cfg_next.reset_low_time        = wr_data;
                IDX_PRES_DELAY: cfg_next.presence_sample_delay = wr_data;
                IDX_SLOT_TIME:  cfg_next.slot_time             = wr_data;
                IDX_SLOT_LOW:   cfg_next.slot_low_time         = wr_data;
                IDX_READ_DELAY: cfg_next.read_sample_delay     = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time        <= owm_pkg::RESET_LOW_TIME_RST;
            cfg_reg.presence_sample_delay <= owm_pkg::PRESENCE_SAMPLE_DELAY_RST;
            cfg_reg.slot_time             <= owm_pkg::SLOT_TIME_RST;
            cfg_reg.slot_low_time         <= owm_pkg::SLOT_LOW_TIME_RST;
            cfg_reg.read_sample_delay     <= owm_pkg::READ_SAMPLE_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/owm_seq.sv =====
`default_nettype none

module owm_seq (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               step,
    input  wire owm_pkg::cfg_t                cfg,
    input  wire                               start_req,
    input  wire [1:0]                         mode,
    input  wire [owm_pkg::BITS_PER_BYTE-1:0]  write_byte,
    input  wire                               line_in,
    output owm_pkg::step_res_t                res
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_WR_SLOT  = 3'd3;
    localparam logic [2:0] PH_RD_LOW   = 3'd4;
    localparam logic [2:0] PH_RD_WAIT  = 3'd5;
    localparam logic [2:0] PH_RD_PAD   = 3'd6;

    localparam logic [1:0] MODE_RESET  = owm_pkg::MODE_RESET;
    localparam logic [1:0] MODE_WRITE  = owm_pkg::MODE_WRITE;
    localparam logic [1:0] MODE_READ   = owm_pkg::MODE_READ;
    localparam logic [1:0] MODE_UNUSED = owm_pkg::MODE_UNUSED;

    localparam int TW = owm_pkg::TIME_W;
    localparam int BW = owm_pkg::BITS_PER_BYTE;
    localparam int IW = owm_pkg::BIT_IDX_W;
    localparam logic [IW-1:0] LAST_BIT = IW'(BW - 1);

    logic [2:0]    phase_reg,    phase_next;
    logic [TW-1:0] tick_reg,     tick_next;
    logic [IW-1:0] bit_idx_reg,  bit_idx_next;
    logic [1:0]    kind_reg,     kind_next;
    logic [BW-1:0] shift_reg,    shift_next;
    logic          pres_reg,     pres_next;
    logic [BW-1:0] last_rd_reg,  last_rd_next;

    // state after a possible command start on this tick
    logic [2:0]    ph_c;
    logic [TW-1:0] tc_c;
    logic [IW-1:0] bi_c;
    logic [1:0]    kind_c;
    logic [BW-1:0] sh_c;

    logic [TW:0]   tc_inc;
    logic [TW:0]   rd_total;
    logic [TW-1:0] eff_reset_low;
    logic [TW-1:0] eff_pres_delay;
    logic [TW-1:0] eff_slot;
    logic [TW-1:0] eff_slot_low;
    logic [TW-1:0] eff_read_delay;
    logic          slot_end;
    logic          drive;
    logic          done;

    function automatic logic [TW-1:0] eff_time(input logic [TW-1:0] v);
        eff_time = (v == '0) ? TW'(1) : v;
    endfunction

    assign eff_reset_low  = eff_time(cfg.reset_low_time);
    assign eff_pres_delay = eff_time(cfg.presence_sample_delay);
    assign eff_slot       = eff_time(cfg.slot_time);
    assign eff_slot_low   = eff_time(cfg.slot_low_time);
    assign eff_read_delay = eff_time(cfg.read_sample_delay);
    assign rd_total       = {1'b0, eff_slot_low} + {1'b0, eff_read_delay};

    always_comb
    begin
        ph_c   = phase_reg;
        tc_c   = tick_reg;
        bi_c   = bit_idx_reg;
        kind_c = kind_reg;
        sh_c   = shift_reg;
        if (phase_reg == PH_IDLE && start_req && mode != MODE_UNUSED)
        begin
            kind_c = mode;
            tc_c   = '0;
            bi_c   = '0;
            case (mode)
                MODE_RESET:
                begin
                    ph_c = PH_RST_LOW;
                end
                MODE_WRITE:
                begin
                    sh_c = write_byte;
                    ph_c = PH_WR_SLOT;
                end
                default:
                begin
                    sh_c = '0;
                    ph_c = PH_RD_LOW;
                end
            endcase
        end
    end

    assign tc_inc = {1'b0, tc_c} + (TW+1)'(1);

    always_comb
    begin
        phase_next   = ph_c;
        tick_next    = tc_c;
        bit_idx_next = bi_c;
        kind_next    = kind_c;
        shift_next   = sh_c;
        pres_next    = pres_reg;
        last_rd_next = last_rd_reg;
        drive        = 1'b0;
        done         = 1'b0;
        slot_end     = 1'b0;

        case (ph_c)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_RST_LOW:
            begin
                drive     = 1'b1;
                tick_next = tc_inc[TW-1:0];
                if (tc_inc >= {1'b0, eff_reset_low})
                begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = '0;
                end
            end
            PH_RST_WAIT:
            begin
                tick_next = tc_inc[TW-1:0];
                if (tc_inc >= {1'b0, eff_pres_delay})
                begin
                    pres_next  = ~line_in;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    done       = 1'b1;
                end
            end
            PH_WR_SLOT:
            begin
                // a one is released after the low pulse, a zero stays low all slot
                drive     = sh_c[bi_c] ? (tc_c < eff_slot_low) : 1'b1;
                tick_next = tc_inc[TW-1:0];
                if (tc_inc >= {1'b0, eff_slot})
                begin
                    slot_end = 1'b1;
                end
            end
            PH_RD_LOW:
            begin
                drive     = 1'b1;
                tick_next = tc_inc[TW-1:0];
                if (tc_inc >= {1'b0, eff_slot_low})
                begin
                    phase_next = PH_RD_WAIT;
                    tick_next  = '0;
                end
            end
            PH_RD_WAIT:
            begin
                tick_next = tc_inc[TW-1:0];
                if (tc_inc >= {1'b0, eff_read_delay})
                begin
                    shift_next[bi_c] = sh_c[bi_c] | line_in;
                    if (rd_total < {1'b0, eff_slot})
                    begin
                        phase_next = PH_RD_PAD;
                        tick_next  = rd_total[TW-1:0];
                    end
                    else
                    begin
                        slot_end = 1'b1;
                    end
                end
            end
            PH_RD_PAD:
            begin
                tick_next = tc_inc[TW-1:0];
                if (tc_inc >= {1'b0, eff_slot})
                begin
                    slot_end = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (slot_end)
        begin
            tick_next = '0;
            if (bi_c == LAST_BIT)
            begin
                if (kind_c == MODE_READ)
                begin
                    last_rd_next = shift_next;
                end
                phase_next   = PH_IDLE;
                bit_idx_next = '0;
                done         = 1'b1;
            end
            else
            begin
                bit_idx_next = bi_c + IW'(1);
                phase_next   = (kind_c == MODE_READ) ? PH_RD_LOW : PH_WR_SLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            kind_reg    <= MODE_RESET;
            shift_reg   <= '0;
            pres_reg    <= 1'b0;
            last_rd_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            kind_reg    <= kind_next;
            shift_reg   <= shift_next;
            pres_reg    <= pres_next;
            last_rd_reg <= last_rd_next;
        end
    end

    assign res.drive_low = drive;
    assign res.busy_res  = (ph_c != PH_IDLE);
    assign res.done_res  = done;
    assign res.presence  = pres_next;
    assign res.read_byte = last_rd_next;

endmodule

`default_nettype wire

// ===== rtl/one_wire_bus_master_core.sv =====
// one-wire bus master, one input request per microsecond tick
// registers: input reg, then result reg; a tick step is one pass of the sequencer logic
// throughput: one request per clock unless out_stall holds a full result register
// reset: asynchronous, active low; sequencer idle, timing registers at their defaults
`default_nettype none

module one_wire_bus_master_core (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire                               start_req,
    input  wire [1:0]                         mode,
    input  wire [owm_pkg::BITS_PER_BYTE-1:0]  write_byte,
    input  wire                               line_in,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic                              drive_low,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              presence,
    output logic [owm_pkg::BITS_PER_BYTE-1:0] read_byte,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [owm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [owm_pkg::TIME_W-1:0]         cfg_data
);

    owm_pkg::cfg_t      cfg;
    owm_pkg::step_res_t step_res;

    logic                             in_vld_reg, in_vld_next;
    logic                             start_reg;
    logic [1:0]                       mode_reg;
    logic [owm_pkg::BITS_PER_BYTE-1:0] wbyte_reg;
    logic                             line_reg;

    logic                             out_vld_reg, out_vld_next;
    owm_pkg::step_res_t               res_reg;

    logic in_accept;
    logic out_free;
    logic step;

    assign cfg_ready = 1'b1;

    owm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // result register can take a new value when empty or being drained
    assign out_free  = ~out_vld_reg | ~out_stall;
    assign step      = in_vld_reg & out_free;
    assign in_stall  = in_vld_reg & ~out_free;
    assign in_accept = in_valid & ~in_stall;

    assign in_vld_next  = in_accept | (in_vld_reg & ~step);
    assign out_vld_next = step | (out_vld_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            start_reg <= start_req;
            mode_reg  <= mode;
            wbyte_reg <= write_byte;
            line_reg  <= line_in;
        end
        if (step)
        begin
            res_reg <= step_res;
        end
    end

    owm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg),
        .start_req  (start_reg),
        .mode       (mode_reg),
        .write_byte (wbyte_reg),
        .line_in    (line_reg),
        .res        (step_res)
    );

    assign out_valid = out_vld_reg;
    assign drive_low = res_reg.drive_low;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign presence  = res_reg.presence;
    assign read_byte = res_reg.read_byte;

endmodule

`default_nettype wire

// ===== rtl/owm_checker.sv =====
`default_nettype none

`include "one_wire_bus_master_core_assert.svh"

module owm_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               out_valid,
    input wire                               out_stall,
    input wire                               drive_low,
    input wire                               busy_res,
    input wire                               done_res,
    input wire                               presence,
    input wire [owm_pkg::BITS_PER_BYTE-1:0]  read_byte
);

    // a stalled result stays offered
    `OWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // a stalled result keeps its payload
    `OWM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
        $stable({drive_low, busy_res, done_res, presence, read_byte}))

    // the finishing tick still counts as busy
    `OWM_ASSERT_NOW(a_done_busy, clk, rst_n, out_valid && done_res, busy_res)

    // an idle master never pulls the line
    `OWM_ASSERT_NOW(a_idle_release, clk, rst_n, out_valid && !busy_res, !drive_low)

endmodule

bind one_wire_bus_master_core owm_checker u_owm_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = owm_pkg::TIME_W;
    localparam int BW = owm_pkg::BITS_PER_BYTE;
    localparam int IW = owm_pkg::BIT_IDX_W;
    localparam int CW = owm_pkg::CFG_IDX_W;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_HEAVY  = 82;
    localparam int IDLE_LIGHT  = 22;

    typedef enum logic [1:0] {
        CMD_RESET = owm_pkg::MODE_RESET,
        CMD_WRITE = owm_pkg::MODE_WRITE,
        CMD_READ  = owm_pkg::MODE_READ,
        CMD_NONE  = owm_pkg::MODE_UNUSED
    } cmd_t;

    typedef enum logic [CW-1:0] {
        REG_RESET_LOW      = owm_pkg::REG_RESET_LOW_TIME,
        REG_PRESENCE_DELAY = owm_pkg::REG_PRESENCE_SAMPLE_DELAY,
        REG_SLOT           = owm_pkg::REG_SLOT_TIME,
        REG_SLOT_LOW       = owm_pkg::REG_SLOT_LOW_TIME,
        REG_READ_DELAY     = owm_pkg::REG_READ_SAMPLE_DELAY
    } reg_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_WR_SLOT,
        SEQ_RD_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_PAD
    } seq_t;

    typedef struct packed {
        logic          start_req;
        logic [1:0]    mode;
        logic [BW-1:0] write_byte;
        logic          line_in;
    } tick_req_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          start_req = 1'b0;
    logic [1:0]    mode = '0;
    logic [BW-1:0] write_byte = '0;
    logic          line_in = 1'b1;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          drive_low;
    logic          busy_res;
    logic          done_res;
    logic          presence;
    logic [BW-1:0] read_byte;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [CW-1:0] cfg_index = '0;
    logic [TW-1:0] cfg_data = '0;

    // bus master mirror
    owm_pkg::cfg_t timing = '{owm_pkg::RESET_LOW_TIME_RST,
                              owm_pkg::PRESENCE_SAMPLE_DELAY_RST,
                              owm_pkg::SLOT_TIME_RST,
                              owm_pkg::SLOT_LOW_TIME_RST,
                              owm_pkg::READ_SAMPLE_DELAY_RST};
    seq_t          seq = SEQ_IDLE;
    logic [TW-1:0] tick_cnt = '0;
    logic [IW-1:0] bit_idx = '0;
    cmd_t          cmd_kind = CMD_RESET;
    logic [BW-1:0] shift_reg = '0;
    logic          pres_flag = 1'b0;
    logic [BW-1:0] last_rd = '0;

    tick_req_t          tick_queue[$];
    owm_pkg::step_res_t outputs_due[$];

    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;
    int            mismatches = 0;
    int            cycle_count = 0;

    one_wire_bus_master_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_req  (start_req),
        .mode       (mode),
        .write_byte (write_byte),
        .line_in    (line_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive_low  (drive_low),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .presence   (presence),
        .read_byte  (read_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // a timing value of zero counts as one tick
    function automatic logic [TW:0] at_least_one(input logic [TW-1:0] v);
        return (v == '0) ? (TW+1)'(1) : {1'b0, v};
    endfunction

    function automatic logic close_slot();
        tick_cnt = '0;
        if (bit_idx == IW'(BW - 1))
        begin
            if (cmd_kind == CMD_READ)
                last_rd = shift_reg;
            seq = SEQ_IDLE;
            bit_idx = '0;
            return 1'b1;
        end
        bit_idx++;
        seq = (cmd_kind == CMD_READ) ? SEQ_RD_LOW : SEQ_WR_SLOT;
        return 1'b0;
    endfunction

    task automatic step_bus_master(input tick_req_t t, output owm_pkg::step_res_t r);
        logic        wbit;
        logic [TW:0] span;
        r = '0;
        if (seq == SEQ_IDLE && t.start_req && t.mode != CMD_NONE)
        begin
            cmd_kind = cmd_t'(t.mode);
            tick_cnt = '0;
            bit_idx = '0;
            case (cmd_kind)
                CMD_RESET: seq = SEQ_RST_LOW;
                CMD_WRITE:
                begin
                    shift_reg = t.write_byte;
                    seq = SEQ_WR_SLOT;
                end
                default:
                begin
                    shift_reg = '0;
                    seq = SEQ_RD_LOW;
                end
            endcase
        end
        r.busy_res = (seq != SEQ_IDLE);
        case (seq)
            SEQ_RST_LOW:
            begin
                r.drive_low = 1'b1;
                tick_cnt++;
                if (tick_cnt >= at_least_one(timing.reset_low_time))
                begin
                    seq = SEQ_RST_WAIT;
                    tick_cnt = '0;
                end
            end
            SEQ_RST_WAIT:
            begin
                tick_cnt++;
                if (tick_cnt >= at_least_one(timing.presence_sample_delay))
                begin
                    pres_flag = ~t.line_in;
                    seq = SEQ_IDLE;
                    tick_cnt = '0;
                    r.done_res = 1'b1;
                end
            end
            SEQ_WR_SLOT:
            begin
                // a one is released after the low pulse, a zero stays low all slot
                wbit = shift_reg[bit_idx];
                r.drive_low = wbit ? (tick_cnt < at_least_one(timing.slot_low_time)) : 1'b1;
                tick_cnt++;
                if (tick_cnt >= at_least_one(timing.slot_time))
                    r.done_res = close_slot();
            end
            SEQ_RD_LOW:
            begin
                r.drive_low = 1'b1;
                tick_cnt++;
                if (tick_cnt >= at_least_one(timing.slot_low_time))
                begin
                    seq = SEQ_RD_WAIT;
                    tick_cnt = '0;
                end
            end
            SEQ_RD_WAIT:
            begin
                tick_cnt++;
                if (tick_cnt >= at_least_one(timing.read_sample_delay))
                begin
                    shift_reg[bit_idx] = shift_reg[bit_idx] | t.line_in;
                    span = at_least_one(timing.slot_low_time)
                         + at_least_one(timing.read_sample_delay);
                    if (span < at_least_one(timing.slot_time))
                    begin
                        seq = SEQ_RD_PAD;
                        tick_cnt = span[TW-1:0];
                    end
                    else
                        r.done_res = close_slot();
                end
            end
            SEQ_RD_PAD:
            begin
                tick_cnt++;
                if (tick_cnt >= at_least_one(timing.slot_time))
                    r.done_res = close_slot();
            end
            default: seq = SEQ_IDLE;
        endcase
        r.presence = pres_flag;
        r.read_byte = last_rd;
    endtask

    function automatic tick_req_t tick(input logic s, input cmd_t m,
                                       input logic [BW-1:0] b, input logic l);
        return tick_req_t'{s, m, b, l};
    endfunction

    function automatic tick_req_t random_tick();
        tick_req_t t;
        t.start_req = ($urandom_range(0, 3) == 0);
        t.mode = ($urandom_range(0, 9) < 9) ? 2'($urandom_range(0, 2)) : CMD_NONE;
        t.write_byte = BW'($urandom);
        t.line_in = 1'($urandom);
        return t;
    endfunction

    function automatic owm_pkg::cfg_t short_timing();
        owm_pkg::cfg_t c;
        c.reset_low_time = TW'($urandom_range(0, 12));
        c.presence_sample_delay = TW'($urandom_range(0, 12));
        c.slot_time = TW'($urandom_range(0, 14));
        c.slot_low_time = TW'($urandom_range(0, 6));
        c.read_sample_delay = TW'($urandom_range(0, 6));
        return c;
    endfunction

    // leaves cfg_valid high so back-to-back writes need only one assignment per edge
    task automatic write_reg(input reg_t idx, input logic [TW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_timing(input owm_pkg::cfg_t c);
        write_reg(REG_RESET_LOW, c.reset_low_time);
        write_reg(REG_PRESENCE_DELAY, c.presence_sample_delay);
        write_reg(REG_SLOT, c.slot_time);
        write_reg(REG_SLOT_LOW, c.slot_low_time);
        write_reg(REG_READ_DELAY, c.read_sample_delay);
        cfg_valid <= 1'b0;
        timing = c;
    endtask

    task automatic settle();
        while (tick_queue.size() != 0 || in_valid || outputs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic begin_phase(input owm_pkg::cfg_t c, input int send_pct, input int recv_pct);
        settle();
        program_timing(c);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic queue_random(input int n);
        repeat (n) tick_queue.push_back(random_tick());
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // sender
    always @(posedge clk)
    begin : drv
        owm_pkg::step_res_t r;
        tick_req_t nxt;
        if (in_valid && !in_stall)
        begin
            step_bus_master(tick_req_t'{start_req, mode, write_byte, line_in}, r);
            outputs_due.push_back(r);
        end
        if (!in_valid || !in_stall)
        begin
            if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = tick_queue.pop_front();
                in_valid <= 1'b1;
                start_req <= nxt.start_req;
                mode <= nxt.mode;
                write_byte <= nxt.write_byte;
                line_in <= nxt.line_in;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : mon
        owm_pkg::step_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outputs_due.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = outputs_due.pop_front();
                check_field("drive_low", 8'(want.drive_low), 8'(drive_low));
                check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                check_field("done_res", 8'(want.done_res), 8'(done_res));
                check_field("presence", 8'(want.presence), 8'(presence));
                check_field("read_byte", want.read_byte, read_byte);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all timing zero: every step is one tick, write-one slots stay low
        program_timing('0);
        tick_queue.push_back(tick(1'b1, CMD_RESET, 8'h00, 1'b1));
        tick_queue.push_back(tick(1'b0, CMD_RESET, 8'h00, 1'b0));
        tick_queue.push_back(tick(1'b1, CMD_NONE, 8'hFF, 1'b0));
        tick_queue.push_back(tick(1'b1, CMD_WRITE, 8'hFF, 1'b0));
        // starts during the write are ignored
        repeat (7) tick_queue.push_back(tick(1'b1, CMD_READ, 8'h00, 1'b1));
        for (int i = 0; i < 16; i++)
            tick_queue.push_back(tick(i == 0, CMD_READ, 8'h00, (i % 4) >= 2));

        begin_phase(short_timing(), 0, 0);
        queue_random(130);
        hold_requests++;

        begin_phase(short_timing(), IDLE_HEAVY, 0);
        queue_random(130);

        begin_phase(short_timing(), 0, IDLE_HEAVY);
        queue_random(130);

        begin_phase(short_timing(), IDLE_LIGHT, IDLE_LIGHT);
        queue_random(130);

        begin_phase(short_timing(), 0, 0);
        queue_random(130);

        begin_phase(owm_pkg::cfg_t'{10'd1, 10'd1, 10'd1, 10'd1, 10'd1}, 0, IDLE_HEAVY);
        queue_random(120);

        // widest timing values with a short presence wait: one full reset pulse,
        // then whatever follows
        begin_phase(owm_pkg::cfg_t'{10'd1023, 10'd1, 10'd1023, 10'd1023, 10'd1023},
                    0, 0);
        tick_queue.push_back(tick(1'b1, CMD_RESET, 8'h00, 1'b1));
        queue_random(1040);

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
